>>> rtl/apw_pkg.sv
// ============================================================================
// apw_pkg: shared types and constants of the anchored point to world transform
// Widths of quaternion, rotation entries and fixed-point words, the register
// index codes and the tag that travels with each item through the divider.
// ============================================================================
package apw_pkg;

	localparam int QW    = 16;  // quaternion component, Q2.14
	localparam int RW    = 22;  // rotation entry, Q.16, magnitude at most 2^20
	localparam int CW    = 32;  // Q16.16 word
	localparam int PW    = 40;  // stage-one vector after saturation
	localparam int DSTG  = 8;   // divider stages
	localparam int DBITS = 4;   // quotient bits per divider stage

	typedef logic signed [QW-1:0] quat_t;
	typedef logic signed [RW-1:0] rent_t;
	typedef rent_t [2:0][2:0]     rmat_t;
	typedef logic signed [CW-1:0] fix_t;

	typedef struct packed {
		logic       inf;
		logic       clip;
		logic [2:0] neg;
		logic [2:0] ovf;
	} dtag_t;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_SPOS_X  = 3'd0;
	localparam reg_idx_t REG_SPOS_Y  = 3'd1;
	localparam reg_idx_t REG_SPOS_Z  = 3'd2;
	localparam reg_idx_t REG_SQUAT_X = 3'd3;
	localparam reg_idx_t REG_SQUAT_Y = 3'd4;
	localparam reg_idx_t REG_SQUAT_Z = 3'd5;
	localparam reg_idx_t REG_SQUAT_W = 3'd6;

	localparam quat_t QUAT_ONE = 16'sd16384;

endpackage

>>> rtl/anchored_point_to_world.sv
// ============================================================================
// anchored_point_to_world: camera-relative homogeneous point to world x, y, z
// Rotates and translates by the sensor pose, then by the frame pose, divides
// by w and saturates to Q16.16.
// ============================================================================
//  channel  dir  content
//  s_*      in   frame pose and homogeneous point, one transfer per point
//  m_*      out  world x, y, z with at_infinity and clipped flags
//  cfg_*    in   sensor pose registers, written one per cycle
//
// One point can enter every cycle unless a stall on m_tready has filled every
// stage; a result leaves after the 17 register stages (two for the frame rotation,
// six for the two matrix products, eight for the 32 quotient bits, one for saturation).
// Each stage advances when it is empty or the stage after it advances, so a
// stall on m_tready fills bubbles first and loses nothing.
// Reset clears the stage valid bits and loads the identity sensor pose; the
// sensor rotation follows a register write through both registers of u_srot.
module anchored_point_to_world (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// frame_pos_x, frame_pos_y, frame_pos_z, frame_quat_x, frame_quat_y,
	// frame_quat_z, frame_quat_w, point_hx, point_hy, point_hz, point_hw
	input  logic [287:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// world_x, world_y, world_z
	output logic [95:0]  m_tdata,
	// at_infinity, clipped
	output logic [1:0]   m_tuser
);
	import apw_pkg::*;

	localparam int NSTG = 9 + DSTG;
	localparam int DV0  = 8;

	// Configuration registers.
	fix_t  spos_q [3];
	quat_t sqx_q, sqy_q, sqz_q, sqw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spos_q <= '{default: '0};
			sqx_q  <= '0;
			sqy_q  <= '0;
			sqz_q  <= '0;
			sqw_q  <= QUAT_ONE;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SPOS_X:  spos_q[0] <= cfg_data;
				REG_SPOS_Y:  spos_q[1] <= cfg_data;
				REG_SPOS_Z:  spos_q[2] <= cfg_data;
				REG_SQUAT_X: sqx_q     <= cfg_data[QW-1:0];
				REG_SQUAT_Y: sqy_q     <= cfg_data[QW-1:0];
				REG_SQUAT_Z: sqz_q     <= cfg_data[QW-1:0];
				REG_SQUAT_W: sqw_q     <= cfg_data[QW-1:0];
				default: ;
			endcase
		end
	end

	rmat_t rs;
	apw_rot u_srot (
		.clk (clk), .en_a(1'b1), .en_b(1'b1),
		.qx(sqx_q), .qy(sqy_q), .qz(sqz_q), .qw(sqw_q), .rot(rs)
	);

	// Stage control.
	logic [NSTG-1:0] v_q;
	logic [NSTG:0]   en;

	always_comb begin
		en[NSTG] = m_tready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = v_q[NSTG-1];

	// Stage 1: capture, frame quaternion products.
	fix_t tf_s1 [3], h_s1 [3], hw_s1;
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				tf_s1[i] <= s_tdata[32*i +: 32];
				h_s1[i]  <= s_tdata[160 + 32*i +: 32];
			end
			hw_s1 <= s_tdata[287:256];
		end
	end

	rmat_t rf;
	apw_rot u_frot (
		.clk (clk), .en_a(en[0]), .en_b(en[1]),
		.qx(s_tdata[111:96]), .qy(s_tdata[127:112]),
		.qz(s_tdata[143:128]), .qw(s_tdata[159:144]), .rot(rf)
	);

	// Stage 2: frame rotation entries.
	fix_t tf_s2 [3], h_s2 [3], hw_s2;
	always_ff @(posedge clk) begin
		if (en[1]) begin
			tf_s2 <= tf_s1;
			h_s2  <= h_s1;
			hw_s2 <= hw_s1;
		end
	end

	// Stage 3: sensor rotation and translation products.
	logic signed [RW+CW-1:0] ph_s3 [3][3];
	logic signed [63:0]      th_s3 [3];
	fix_t  tf_s3 [3], hw_s3;
	rmat_t rf_s3;
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					ph_s3[i][j] <= $signed(rs[i][j]) * h_s2[j];
				end
				th_s3[i] <= spos_q[i] * hw_s2;
			end
			tf_s3 <= tf_s2;
			hw_s3 <= hw_s2;
			rf_s3 <= rf;
		end
	end

	// Stage 4: sum, round to Q.16 and saturate to the intermediate width.
	logic signed [PW-1:0] p_d [3];
	logic                 clip1_d;
	always_comb begin
		logic signed [63:0] a, sh;
		clip1_d = 1'b0;
		for (int i = 0; i < 3; i++) begin
			a  = th_s3[i] + 64'(ph_s3[i][0]) + 64'(ph_s3[i][1]) + 64'(ph_s3[i][2]);
			sh = (a + 64'sd32768) >>> 16;
			if ((&sh[63:PW-1]) || !(|sh[63:PW-1])) begin
				p_d[i] = sh[PW-1:0];
			end else begin
				clip1_d = 1'b1;
				p_d[i]  = sh[63] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
			end
		end
	end

	logic signed [PW-1:0] p_s4 [3];
	logic  clip_s4;
	fix_t  tf_s4 [3], hw_s4;
	rmat_t rf_s4;
	always_ff @(posedge clk) begin
		if (en[3]) begin
			p_s4    <= p_d;
			clip_s4 <= clip1_d;
			tf_s4   <= tf_s3;
			hw_s4   <= hw_s3;
			rf_s4   <= rf_s3;
		end
	end

	// Stage 5: frame rotation products, the 40-bit vector split in halves.
	localparam int HB = PW / 2;
	logic signed [RW+HB-1:0] hi_s5 [3][3];
	logic signed [RW+HB:0]   lo_s5 [3][3];
	logic signed [63:0]      tt_s5 [3];
	logic clip_s5;
	fix_t hw_s5;
	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					hi_s5[i][j] <= $signed(rf_s4[i][j]) * $signed(p_s4[j][PW-1:HB]);
					lo_s5[i][j] <= $signed(rf_s4[i][j]) * $signed({1'b0, p_s4[j][HB-1:0]});
				end
				tt_s5[i] <= tf_s4[i] * hw_s4;
			end
			clip_s5 <= clip_s4;
			hw_s5   <= hw_s4;
		end
	end

	// Stage 6: merge the halves.
	logic signed [63:0] m_s6 [3][3], tt_s6 [3];
	logic clip_s6;
	fix_t hw_s6;
	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					m_s6[i][j] <= (64'(hi_s5[i][j]) <<< HB) + 64'(lo_s5[i][j]);
				end
			end
			tt_s6   <= tt_s5;
			clip_s6 <= clip_s5;
			hw_s6   <= hw_s5;
		end
	end

	// Stage 7: numerator.
	logic signed [63:0] n_s7 [3];
	logic clip_s7;
	fix_t hw_s7;
	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int i = 0; i < 3; i++) begin
				n_s7[i] <= tt_s6[i] + m_s6[i][0] + m_s6[i][1] + m_s6[i][2];
			end
			clip_s7 <= clip_s6;
			hw_s7   <= hw_s6;
		end
	end

	// Stage 8: magnitudes, signs and quotient overflow ahead of the divider.
	logic [CW-1:0] rem_s8 [3], low_s8 [3], dvs_s8;
	dtag_t         tag_s8;
	always_ff @(posedge clk) begin
		logic [63:0]   nabs;
		logic [CW-1:0] dabs;
		if (en[7]) begin
			dabs = hw_s7[CW-1] ? CW'(-hw_s7) : CW'(hw_s7);
			for (int i = 0; i < 3; i++) begin
				nabs = n_s7[i][63] ? 64'(-n_s7[i]) : 64'(n_s7[i]);
				rem_s8[i]      <= nabs[63:32];
				low_s8[i]      <= nabs[31:0];
				tag_s8.ovf[i]  <= nabs[63:32] >= dabs;
				tag_s8.neg[i]  <= n_s7[i][63] ^ hw_s7[CW-1];
			end
			dvs_s8       <= dabs;
			tag_s8.inf   <= (hw_s7 == '0);
			tag_s8.clip  <= clip_s7;
		end
	end

	logic [CW-1:0] quo [3];
	dtag_t         tag_d;
	apw_div u_div (
		.clk(clk), .en(en[DV0 +: DSTG]),
		.rem_in(rem_s8), .low_in(low_s8), .dvs_in(dvs_s8), .tag_in(tag_s8),
		.quo(quo), .tag_out(tag_d)
	);

	// Last stage: sign and saturation.
	logic [95:0] world_s17;
	logic        inf_s17, clip_s17;
	always_ff @(posedge clk) begin
		logic       c;
		logic [CW-1:0] q;
		if (en[NSTG-1]) begin
			c = tag_d.clip;
			for (int i = 0; i < 3; i++) begin
				q = quo[i];
				if (tag_d.inf) begin
					world_s17[32*i +: 32] <= '0;
				end else if (tag_d.ovf[i] ||
						(tag_d.neg[i] ? (q > 32'h8000_0000) : q[CW-1])) begin
					c = 1'b1;
					world_s17[32*i +: 32] <= tag_d.neg[i] ? 32'h8000_0000 : 32'h7fff_ffff;
				end else begin
					world_s17[32*i +: 32] <= tag_d.neg[i] ? -q : q;
				end
			end
			inf_s17  <= tag_d.inf;
			clip_s17 <= c && !tag_d.inf;
		end
	end

	assign m_tdata = world_s17;
	assign m_tuser = {clip_s17, inf_s17};

`ifndef SYNTHESIS
	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
		else $error("point at infinity with nonzero result");
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while the output stage is empty");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && v_q[NSTG-2] |-> !s_tready || !v_q[0] || !(&v_q))
		else $error("full pipeline accepted a transfer under stall");
`endif

endmodule

>>> rtl/apw_rot.sv
// ============================================================================
// apw_rot: quaternion to rotation matrix
// Two register stages: the nine component products, then the matrix entries
// rounded from Q.28 to Q.16.
// ============================================================================
module apw_rot (
	input  logic           clk,
	input  logic           en_a,
	input  logic           en_b,
	input  apw_pkg::quat_t qx,
	input  apw_pkg::quat_t qy,
	input  apw_pkg::quat_t qz,
	input  apw_pkg::quat_t qw,
	output apw_pkg::rmat_t rot
);
	import apw_pkg::*;

	localparam int MW = 36;
	localparam logic signed [MW-1:0] ONE_Q28 = 36'sd268435456;

	logic signed [2*QW-1:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, xw_s1, yw_s1, zw_s1;
	rmat_t rot_s2;
	rmat_t rot_d;

	function automatic rent_t round_ent(input logic signed [MW-1:0] m);
		logic signed [MW-1:0] t;
		t = m + 36'sd2048;
		return t[RW+11:12];
	endfunction

	always_ff @(posedge clk) begin
		if (en_a) begin
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			zz_s1 <= qz * qz;
			xy_s1 <= qx * qy;
			xz_s1 <= qx * qz;
			yz_s1 <= qy * qz;
			xw_s1 <= qx * qw;
			yw_s1 <= qy * qw;
			zw_s1 <= qz * qw;
		end
	end

	always_comb begin
		rot_d[0][0] = round_ent(ONE_Q28 - ((MW'(yy_s1) + MW'(zz_s1)) <<< 1));
		rot_d[0][1] = round_ent((MW'(xy_s1) - MW'(zw_s1)) <<< 1);
		rot_d[0][2] = round_ent((MW'(xz_s1) + MW'(yw_s1)) <<< 1);
		rot_d[1][0] = round_ent((MW'(xy_s1) + MW'(zw_s1)) <<< 1);
		rot_d[1][1] = round_ent(ONE_Q28 - ((MW'(xx_s1) + MW'(zz_s1)) <<< 1));
		rot_d[1][2] = round_ent((MW'(yz_s1) - MW'(xw_s1)) <<< 1);
		rot_d[2][0] = round_ent((MW'(xz_s1) - MW'(yw_s1)) <<< 1);
		rot_d[2][1] = round_ent((MW'(yz_s1) + MW'(xw_s1)) <<< 1);
		rot_d[2][2] = round_ent(ONE_Q28 - ((MW'(xx_s1) + MW'(yy_s1)) <<< 1));
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			rot_s2 <= rot_d;
		end
	end

	assign rot = rot_s2;

endmodule

>>> rtl/apw_div.sv
// ============================================================================
// apw_div: pipelined restoring divider, three lanes
// Each stage retires four quotient bits of a 64 by 32 bit unsigned division
// whose quotient is known to fit in 32 bits; a tag rides along.
// ============================================================================
module apw_div (
	input  logic                       clk,
	input  logic [apw_pkg::DSTG-1:0]   en,
	input  logic [apw_pkg::CW-1:0]     rem_in [3],
	input  logic [apw_pkg::CW-1:0]     low_in [3],
	input  logic [apw_pkg::CW-1:0]     dvs_in,
	input  apw_pkg::dtag_t             tag_in,
	output logic [apw_pkg::CW-1:0]     quo [3],
	output apw_pkg::dtag_t             tag_out
);
	import apw_pkg::*;

	logic [CW-1:0] rem_s [DSTG][3];
	logic [CW-1:0] low_s [DSTG][3];
	logic [CW-1:0] quo_s [DSTG][3];
	logic [CW-1:0] dvs_s [DSTG];
	dtag_t         tag_s [DSTG];

	for (genvar k = 0; k < DSTG; k++) begin : g_stg
		logic [CW-1:0] ri [3];
		logic [CW-1:0] li [3];
		logic [CW-1:0] qi [3];
		logic [CW-1:0] di;
		dtag_t         ti;
		logic [CW-1:0] rn [3];
		logic [CW-1:0] ln [3];
		logic [CW-1:0] qn [3];

		if (k == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					ri[l] = rem_in[l];
					li[l] = low_in[l];
					qi[l] = '0;
				end
				di = dvs_in;
				ti = tag_in;
			end
		end else begin : g_next
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					ri[l] = rem_s[k-1][l];
					li[l] = low_s[k-1][l];
					qi[l] = quo_s[k-1][l];
				end
				di = dvs_s[k-1];
				ti = tag_s[k-1];
			end
		end

		always_comb begin
			logic [CW:0]   t;
			logic [CW-1:0] r, lo, q;
			for (int l = 0; l < 3; l++) begin
				r  = ri[l];
				lo = li[l];
				q  = qi[l];
				for (int s = 0; s < DBITS; s++) begin
					t  = {r, lo[CW-1]};
					lo = {lo[CW-2:0], 1'b0};
					if (t >= {1'b0, di}) begin
						t = t - {1'b0, di};
						q = {q[CW-2:0], 1'b1};
					end else begin
						q = {q[CW-2:0], 1'b0};
					end
					r = t[CW-1:0];
				end
				rn[l] = r;
				ln[l] = lo;
				qn[l] = q;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= rn;
				low_s[k] <= ln;
				quo_s[k] <= qn;
				dvs_s[k] <= di;
				tag_s[k] <= ti;
			end
		end
	end

	assign quo     = quo_s[DSTG-1];
	assign tag_out = tag_s[DSTG-1];

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the anchored point to world transform
// Points stream in against a local fixed-point predictor of the two-stage
// rotation, translation and division. Sensor pose registers change between
// phases, and both stream sides idle and stall at varying rates.
// ----------------------------------------------------------------------------
module tb_top;
	import apw_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		fix_t hw, hz, hy, hx;
		quat_t qw, qz, qy, qx;
		fix_t tz, ty, tx;
	} point_item_t;

	typedef struct packed {
		logic clip;
		logic inf;
		fix_t z, y, x;
	} world_t;

	typedef struct {
		point_item_t pt;
		bit          typed;
		world_t      res;
	} stim_row_t;

	typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_t;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 24;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_idx = '0;
	logic [31:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [287:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;
	logic [1:0]   m_tuser;

	anchored_point_to_world u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	longint    sensor_reg[7];
	world_t    pending_world[$];
	stim_row_t stim_table[$];
	flow_t     flow = FLOW_FREE;
	int        hold_left = 0;
	int        errors = 0;
	int        results_seen = 0;
	int        clipped_seen = 0;
	int        inf_seen = 0;
	int        cycles = 0;

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH result %0d %s: got %0h want %0h", results_seen, what, got, want);
		errors++;
	endtask

	// Rotation entries in Q.16, rounded from the exact Q.28 quaternion products.
	function automatic void rotation_q16(longint x, longint y, longint z, longint w,
			output longint r[3][3]);
		longint m[3][3];
		m[0][0] = (64'sd1 <<< 28) - 2 * (y * y + z * z);
		m[0][1] = 2 * (x * y - z * w);
		m[0][2] = 2 * (x * z + y * w);
		m[1][0] = 2 * (x * y + z * w);
		m[1][1] = (64'sd1 <<< 28) - 2 * (x * x + z * z);
		m[1][2] = 2 * (y * z - x * w);
		m[2][0] = 2 * (x * z - y * w);
		m[2][1] = 2 * (y * z + x * w);
		m[2][2] = (64'sd1 <<< 28) - 2 * (x * x + y * y);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				r[i][j] = (m[i][j] + 2048) >>> 12;
	endfunction

	function automatic world_t world_of_point(point_item_t pt);
		longint rs[3][3], rf[3][3];
		longint h[3], tf[3], mid[3], q[3];
		longint hw, acc;
		logic   clip;
		world_t res;
		clip = 1'b0;
		hw = pt.hw;
		h = '{longint'(pt.hx), longint'(pt.hy), longint'(pt.hz)};
		tf = '{longint'(pt.tx), longint'(pt.ty), longint'(pt.tz)};
		if (hw == 0)
			return '{clip: 1'b0, inf: 1'b1, z: '0, y: '0, x: '0};
		rotation_q16(sensor_reg[3], sensor_reg[4], sensor_reg[5], sensor_reg[6], rs);
		rotation_q16(pt.qx, pt.qy, pt.qz, pt.qw, rf);
		for (int i = 0; i < 3; i++) begin
			acc = sensor_reg[i] * hw;
			for (int j = 0; j < 3; j++)
				acc += rs[i][j] * h[j];
			mid[i] = (acc + 32768) >>> 16;
			if (mid[i] > (64'sd1 <<< 39) - 1) begin
				mid[i] = (64'sd1 <<< 39) - 1;
				clip = 1'b1;
			end else if (mid[i] < -(64'sd1 <<< 39)) begin
				mid[i] = -(64'sd1 <<< 39);
				clip = 1'b1;
			end
		end
		for (int i = 0; i < 3; i++) begin
			acc = tf[i] * hw;
			for (int j = 0; j < 3; j++)
				acc += rf[i][j] * mid[j];
			q[i] = acc / hw;
			if (q[i] > 64'sd2147483647) begin
				q[i] = 64'sd2147483647;
				clip = 1'b1;
			end else if (q[i] < -64'sd2147483648) begin
				q[i] = -64'sd2147483648;
				clip = 1'b1;
			end
		end
		res.x = q[0][31:0];
		res.y = q[1][31:0];
		res.z = q[2][31:0];
		res.inf = 1'b0;
		res.clip = clip;
		return res;
	endfunction

	// Mostly components within +-1.0 and moderate coordinates; the rest is raw noise.
	function automatic point_item_t random_point();
		point_item_t pt;
		int          pick;
		pt = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			pt.qx = $urandom_range(0, 32768) - 16384;
			pt.qy = $urandom_range(0, 32768) - 16384;
			pt.qz = $urandom_range(0, 32768) - 16384;
			pt.qw = $urandom_range(0, 32768) - 16384;
			pt.tx = $signed(pt.tx) >>> $urandom_range(4, 12);
			pt.ty = $signed(pt.ty) >>> $urandom_range(4, 12);
			pt.tz = $signed(pt.tz) >>> $urandom_range(4, 12);
			pt.hx = $signed(pt.hx) >>> $urandom_range(0, 12);
			pt.hy = $signed(pt.hy) >>> $urandom_range(0, 12);
			pt.hz = $signed(pt.hz) >>> $urandom_range(0, 12);
			case ($urandom_range(0, 4))
				0: pt.hw = 32'sh10000;
				1: pt.hw = $signed(pt.hw) >>> 12;
				2: pt.hw = $signed(pt.hw) >>> 24;
				default: pt.hw = $signed(pt.hw) >>> $urandom_range(0, 30);
			endcase
		end
		if ($urandom_range(0, 24) == 0)
			pt.hw = '0;
		return pt;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx <= REG_SQUAT_W)
			sensor_reg[idx] = (idx <= REG_SPOS_Z) ? longint'($signed(data))
				: longint'($signed(data[15:0]));
	endtask

	task automatic load_sensor(logic [31:0] vals[7]);
		for (int i = 0; i < 7; i++)
			write_reg(reg_idx_t'(i), vals[i]);
		// The top index is not a register; the write must change nothing.
		write_reg(reg_idx_t'(7), $urandom);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_world.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_point(point_item_t pt, bit typed, world_t res);
		s_tvalid <= 1'b1;
		s_tdata <= pt;
		do @(posedge clk); while (!s_tready);
		pending_world.push_back(typed ? res : world_of_point(pt));
		if ((flow == FLOW_SRC_IDLE && $urandom_range(0, 99) < 61) ||
				(flow == FLOW_BOTH && $urandom_range(0, 99) < 17)) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic add_row(point_item_t pt, bit typed, world_t res);
		stim_table.push_back('{pt: pt, typed: typed, res: res});
	endtask

	// Sink side: random stalls by phase, plus one long hold-off in phase 1.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			case (flow)
				FLOW_SNK_STALL: m_tready <= ($urandom_range(0, 99) >= 61);
				FLOW_BOTH:      m_tready <= ($urandom_range(0, 99) >= 17);
				default:        m_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		world_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata};
			if (pending_world.size() == 0) begin
				report_mismatch("unexpected result", got.x, 0);
			end else begin
				want = pending_world.pop_front();
				if (got.x != want.x) report_mismatch("world_x", got.x, want.x);
				if (got.y != want.y) report_mismatch("world_y", got.y, want.y);
				if (got.z != want.z) report_mismatch("world_z", got.z, want.z);
				if (got.inf != want.inf) report_mismatch("at_infinity", got.inf, want.inf);
				if (got.clip != want.clip) report_mismatch("clipped", got.clip, want.clip);
			end
			results_seen++;
			inf_seen += got.inf;
			clipped_seen += got.clip;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout with %0d results outstanding", pending_world.size());
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		point_item_t pt;
		world_t      none;
		logic [31:0] sensor_set[7];
		none = '0;
		for (int i = 0; i < 7; i++)
			sensor_reg[i] = 0;
		sensor_reg[REG_SQUAT_W] = QUAT_ONE;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity poses at reset: a unit-weight point comes back unchanged.
		pt = '0;
		pt.qw = QUAT_ONE;
		pt.hx = 32'sh10000; pt.hy = 32'sh20000; pt.hz = -32'sh30000; pt.hw = 32'sh10000;
		add_row(pt, 1'b1, '{clip: 1'b0, inf: 1'b0, z: -32'sh30000, y: 32'sh20000,
			x: 32'sh10000});
		// Point at infinity, with everything else at its extremes.
		pt = {32'h0, {3{32'h7fffffff}}, {4{16'h7fff}}, {3{32'h80000000}}};
		add_row(pt, 1'b1, '{clip: 1'b0, inf: 1'b1, z: '0, y: '0, x: '0});
		pt = {32'h0, {3{32'h80000000}}, {4{16'h8000}}, {3{32'h7fffffff}}};
		add_row(pt, 1'b1, '{clip: 1'b0, inf: 1'b1, z: '0, y: '0, x: '0});
		// Extremes of every field, the smallest weights and full-scale quaternions.
		pt = {32'h7fffffff, {3{32'h7fffffff}}, {4{16'h7fff}}, {3{32'h7fffffff}}};
		add_row(pt, 1'b0, none);
		pt = {32'h80000000, {3{32'h80000000}}, {4{16'h8000}}, {3{32'h80000000}}};
		add_row(pt, 1'b0, none);
		pt = {32'h00000001, {3{32'h7fffffff}}, 16'h4000, 48'h0, {3{32'h0}}};
		add_row(pt, 1'b0, none);
		pt = {32'hffffffff, {3{32'h80000000}}, 16'h4000, 48'h0, {3{32'h00010000}}};
		add_row(pt, 1'b0, none);
		// Translation alone drives the output close to full scale while the middle vector fits.
		pt = {32'h00010000, 96'h0, 16'h4000, 48'h0, {3{32'h7fff0000}}};
		add_row(pt, 1'b0, none);
		// Large middle vector that the large weight divides back in range.
		pt = {32'h7fffffff, {3{32'h7fffffff}}, 16'h4000, 48'h0, 96'h0};
		add_row(pt, 1'b0, none);
		pt = {32'h00010000, 32'h00030000, 32'hfffe0000, 32'h00008000,
			16'h2d41, 16'h0, 16'h0, 16'h2d41, 32'h00050000, 32'h0, 32'hfff00000};
		add_row(pt, 1'b0, none);
		pt = {32'hffff0000, 32'h12345678, 32'h9abcdef0, 32'h0fedcba9,
			16'h0000, 16'h4000, 16'h0000, 16'h0000, 32'h1, 32'hffffffff, 32'h55555555};
		add_row(pt, 1'b0, none);
		pt = {32'hfffe0000, 96'h000a0000_fff60000_00140000,
			16'h2000, 16'hc000, 16'h2000, 16'he000, 96'h0};
		add_row(pt, 1'b0, none);
		foreach (stim_table[i])
			send_point(stim_table[i].pt, stim_table[i].typed, stim_table[i].res);
		s_tvalid <= 1'b0;
		wait_drained();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: sensor_set = '{0, 0, 0, 0, 0, 0, 16384};
				1: sensor_set = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
					32'h7fff, 32'h7fff, 32'h7fff, 32'h7fff};
				2: sensor_set = '{32'h80000000, 32'h80000000, 32'h80000000,
					32'hffff8000, 32'h8000, 32'h8000, 32'h8000};
				default: begin
					sensor_set = '{$urandom >> 6, $urandom >> 8, $urandom,
						$urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
						$urandom_range(0, 32768) - 16384, $urandom};
					if (phase == 3)
						sensor_set[3:5] = '{32'h0, 32'h0, 32'hffff0000};
				end
			endcase
			load_sensor(sensor_set);
			flow = flow_t'(phase % 4);
			for (int n = 0; n < 240; n++) begin
				if (phase == 1 && n == 60)
					hold_left = 300;
				if (phase == 4 && n == 120) begin
					s_tvalid <= 1'b0;
					while (pending_world.size() != 0)
						@(posedge clk);
				end
				send_point(random_point(), 1'b0, none);
			end
			s_tvalid <= 1'b0;
			wait_drained();
		end

		$display("checked %0d points over 7 sensor poses and 4 flow patterns", results_seen);
		$display("%0d at infinity, %0d saturated, %0d mismatches", inf_seen, clipped_seen,
			errors);
		if (errors == 0 && pending_world.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
